@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of this project.
// Self-contained; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

@@ hw/rtl/etf_pkg.sv @@
// Package for the escape-time fractal iterator: widths, register map,
// reset values and shared types. Depends on nothing.
package etf_pkg;

    // Fixed-point format of coordinates and z components (signed Q8.24).
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 24;
    localparam int COUNT_WIDTH = 10;
    localparam int LIMIT_WIDTH = 31;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;

    // Configuration port geometry.
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_WIDTH = 5;
    localparam int IDX_WIDTH  = ADDR_WIDTH - 2;

    // Register indexes.
    localparam logic [IDX_WIDTH-1:0] REG_MODE        = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_MAX_ITER    = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_JULIA_C_RE  = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_JULIA_C_IM  = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_MANDEL_LIM  = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_JULIA_LIM   = 3'd5;

    // Mode codes.
    localparam logic MODE_MANDEL = 1'b0;
    localparam logic MODE_JULIA  = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;
    typedef logic [COUNT_WIDTH-1:0]        t_count;
    typedef logic [LIMIT_WIDTH-1:0]        t_limit;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic   mode;
        t_count max_iterations;
        t_coord julia_c_real;
        t_coord julia_c_imag;
        t_limit mandel_escape_limit;
        t_limit julia_escape_limit;
    } t_cfg;

    // Reset values: -0.12 + 0.48i, limit 100, thresholds 10.0 and 4.0.
    localparam t_count RST_MAX_ITER   = 10'd100;
    localparam t_coord RST_C_RE       = -32'sd2013266;
    localparam t_coord RST_C_IM       = 32'sd8053064;
    localparam t_limit RST_MANDEL_LIM = 31'd167772160;
    localparam t_limit RST_JULIA_LIM  = 31'd67108864;

endpackage

@@ hw/rtl/escape_time_fractal_iterator.sv @@
// Top level of the escape-time fractal iterator: sequencer, z update, escape test.
// Depends on etf_pkg, etf_regs and etf_sq_unit.
//
//  channel   | handshake                       | payload
//  ----------+---------------------------------+------------------------------
//  point in  | start && !busy                  | i_x_coord, i_y_coord
//  count out | o_done (one cycle, no stall)    | o_iteration_count
//  config    | psel && penable && pwrite       | paddr, pwdata, prdata
//
// Each iteration registers the squares of z in the square unit (state MUL),
// then runs the escape test and the z update (state STEP). A point's count
// shows when its final STEP state ends, and busy is low again in that same
// cycle, so the next point may start there. Reset is synchronous and active
// low; the result side cannot stall.
module escape_time_fractal_iterator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  etf_pkg::t_coord                 i_x_coord,
    input  etf_pkg::t_coord                 i_y_coord,
    output logic                            o_done,
    output etf_pkg::t_count                 o_iteration_count,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [etf_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [etf_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [etf_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                            pready
);
    import etf_pkg::*;

    localparam int SUM_WIDTH = PROD_WIDTH - FRAC_BITS + 2;
    localparam int PAD_WIDTH = PROD_WIDTH - LIMIT_WIDTH - FRAC_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;

    t_cfg   w_cfg;
    logic [1:0] r_state;
    logic [1:0] n_state;
    t_coord r_zr;
    t_coord r_zi;
    t_coord r_cr;
    t_coord r_ci;
    t_count r_count;
    logic   r_done;
    t_count r_result;
    t_prod  w_rr;
    t_prod  w_ii;
    t_prod  w_ri;
    logic [PROD_WIDTH-1:0] w_mag;
    logic [PROD_WIDTH-1:0] w_thr;
    logic   w_stop;
    t_prod  w_diff;
    t_prod  w_re_sh;
    t_prod  w_im_sh;
    logic signed [SUM_WIDTH-1:0] w_re_sum;
    logic signed [SUM_WIDTH-1:0] w_im_sum;

    // Clamp a widened sum to the signed coordinate range.
    function automatic t_coord f_sat(input logic signed [SUM_WIDTH-1:0] v);
        logic [SUM_WIDTH-COORD_WIDTH:0] hi;
        hi = v[SUM_WIDTH-1:COORD_WIDTH-1];
        if ((&hi) || !(|hi)) begin
            return v[COORD_WIDTH-1:0];
        end else if (v[SUM_WIDTH-1]) begin
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    etf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    etf_sq_unit u_sq (
        .i_clk (i_clk),
        .i_en  (r_state == ST_MUL),
        .i_zr  (r_zr),
        .i_zi  (r_zi),
        .o_rr  (w_rr),
        .o_ii  (w_ii),
        .o_ri  (w_ri)
    );

    // Escape test: |z|^2 against the threshold, both unsigned Q16.48, or the iteration limit reached.
    always_comb begin
        w_mag = unsigned'(w_rr) + unsigned'(w_ii);
        if (w_cfg.mode == MODE_JULIA) begin
            w_thr = {{PAD_WIDTH{1'b0}}, w_cfg.julia_escape_limit, {FRAC_BITS{1'b0}}};
        end else begin
            w_thr = {{PAD_WIDTH{1'b0}}, w_cfg.mandel_escape_limit, {FRAC_BITS{1'b0}}};
        end
        w_stop = (r_count == w_cfg.max_iterations) || !(w_mag < w_thr);
    end

    // Next z: floor-shifted products plus c, then saturated.
    always_comb begin
        w_diff   = w_rr - w_ii;
        w_re_sh  = w_diff >>> FRAC_BITS;
        w_im_sh  = w_ri >>> (FRAC_BITS - 1);
        w_re_sum = SUM_WIDTH'(signed'(w_re_sh[SUM_WIDTH-2:0])) + SUM_WIDTH'(r_cr);
        w_im_sum = SUM_WIDTH'(signed'(w_im_sh[SUM_WIDTH-2:0])) + SUM_WIDTH'(r_ci);
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (start) n_state = ST_MUL;
            ST_MUL:  n_state = ST_STEP;
            ST_STEP: n_state = w_stop ? ST_IDLE : ST_MUL;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_STEP) && w_stop;
        end
    end

    // Datapath registers: load the point, then update z once per iteration.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_count <= '0;
            if (w_cfg.mode == MODE_JULIA) begin
                r_zr <= i_x_coord;
                r_zi <= i_y_coord;
                r_cr <= w_cfg.julia_c_real;
                r_ci <= w_cfg.julia_c_imag;
            end else begin
                r_zr <= '0;
                r_zi <= '0;
                r_cr <= i_x_coord;
                r_ci <= i_y_coord;
            end
        end else if (r_state == ST_STEP) begin
            if (w_stop) begin
                r_result <= r_count;
            end else begin
                r_zr    <= f_sat(w_re_sum);
                r_zi    <= f_sat(w_im_sum);
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign busy              = (r_state != ST_IDLE);
    assign o_done            = r_done;
    assign o_iteration_count = r_result;

endmodule

@@ hw/rtl/etf_regs.sv @@
// Configuration register file behind an APB-style port.
// Depends on etf_pkg for the register map, reset values and t_cfg.
module etf_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [etf_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [etf_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [etf_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                            pready,
    output etf_pkg::t_cfg                   o_cfg
);
    import etf_pkg::*;

    t_cfg                 r_cfg;
    logic [IDX_WIDTH-1:0] w_idx;
    logic                 w_wr;

    assign w_idx  = paddr[ADDR_WIDTH-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode                <= MODE_MANDEL;
            r_cfg.max_iterations      <= RST_MAX_ITER;
            r_cfg.julia_c_real        <= RST_C_RE;
            r_cfg.julia_c_imag        <= RST_C_IM;
            r_cfg.mandel_escape_limit <= RST_MANDEL_LIM;
            r_cfg.julia_escape_limit  <= RST_JULIA_LIM;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MODE:       r_cfg.mode                <= pwdata[0];
                REG_MAX_ITER:   r_cfg.max_iterations      <= pwdata[COUNT_WIDTH-1:0];
                REG_JULIA_C_RE: r_cfg.julia_c_real        <= pwdata[COORD_WIDTH-1:0];
                REG_JULIA_C_IM: r_cfg.julia_c_imag        <= pwdata[COORD_WIDTH-1:0];
                REG_MANDEL_LIM: r_cfg.mandel_escape_limit <= pwdata[LIMIT_WIDTH-1:0];
                REG_JULIA_LIM:  r_cfg.julia_escape_limit  <= pwdata[LIMIT_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back multiplexer, zero-extended to the bus width.
    always_comb begin
        unique case (w_idx)
            REG_MODE:       prdata = DATA_WIDTH'(r_cfg.mode);
            REG_MAX_ITER:   prdata = DATA_WIDTH'(r_cfg.max_iterations);
            REG_JULIA_C_RE: prdata = DATA_WIDTH'(unsigned'(r_cfg.julia_c_real));
            REG_JULIA_C_IM: prdata = DATA_WIDTH'(unsigned'(r_cfg.julia_c_imag));
            REG_MANDEL_LIM: prdata = DATA_WIDTH'(r_cfg.mandel_escape_limit);
            REG_JULIA_LIM:  prdata = DATA_WIDTH'(r_cfg.julia_escape_limit);
            default:        prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/etf_sq_unit.sv @@
// Complex-square unit: forms re*re, im*im and re*im of z, registered.
// Depends on etf_pkg for the coordinate and product types.
module etf_sq_unit (
    input  logic           i_clk,
    input  logic           i_en,
    input  etf_pkg::t_coord i_zr,
    input  etf_pkg::t_coord i_zi,
    output etf_pkg::t_prod  o_rr,
    output etf_pkg::t_prod  o_ii,
    output etf_pkg::t_prod  o_ri
);
    import etf_pkg::*;

    t_prod r_rr;
    t_prod r_ii;
    t_prod r_ri;
    t_prod n_rr;
    t_prod n_ii;
    t_prod n_ri;

    // Three independent full-width signed products.
    always_comb begin
        n_rr = t_prod'(i_zr) * t_prod'(i_zr);
        n_ii = t_prod'(i_zi) * t_prod'(i_zi);
        n_ri = t_prod'(i_zr) * t_prod'(i_zi);
    end

    // Product registers, loaded in state MUL; the sequencer reads them in state STEP.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rr <= n_rr;
            r_ii <= n_ii;
            r_ri <= n_ri;
        end
    end

    assign o_rr = r_rr;
    assign o_ii = r_ii;
    assign o_ri = r_ri;

endmodule

@@ hw/rtl/etf_checker.sv @@
// Port-level checker for the escape-time fractal iterator, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module etf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    // An accepted point makes the block busy in the next cycle.
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)

    // The first cycle of a new point never shows a result beat.
    `ASSERT_NEXT(a_start_no_done, i_clk, i_rst_n, start && !busy, !o_done)

    // A result beat appears only once the block is free again.
    `ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_done, !busy)

    // The block leaves the busy phase only together with its result beat.
    `ASSERT_IMPL(a_fall_done, i_clk, i_rst_n, $fell(busy), o_done)

endmodule

bind escape_time_fractal_iterator etf_checker u_etf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);

@@ bench/tb_escape_time_fractal_iterator.sv @@
// Self-checking testbench for escape_time_fractal_iterator: directed table, then random points.
// Each count is checked against the table value or a predictor of the escape-time iteration.
// Depends on etf_pkg and the escape_time_fractal_iterator RTL.
module tb_escape_time_fractal_iterator;
    timeunit 1ns;
    timeprecision 1ps;

    import etf_pkg::*;

    typedef longint unsigned u64_t;

    localparam int     ONE        = 1 << FRAC_BITS;
    localparam int     NO_WANT    = -1;
    localparam int     DRAIN_MAX  = 4 * 1024 + 16;
    localparam int     MAX_SHOWN  = 10;
    localparam longint COORD_HI   = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam longint COORD_LO   = -COORD_HI - 64'sd1;
    localparam t_coord COORD_TOP  = 32'sh7FFF_FFFF;
    localparam t_coord COORD_BOT  = 32'sh8000_0000;
    localparam logic [DATA_WIDTH-1:0] LIMIT_TOP = 32'h7FFF_FFFF;

    // One count that is still due, with the point that caused it.
    typedef struct {
        t_count count;
        t_coord x;
        t_coord y;
    } pending_t;

    // One row of the directed table: a register write or a point.
    typedef struct {
        bit                    is_write;
        logic [IDX_WIDTH-1:0]  idx;
        logic [DATA_WIDTH-1:0] value;
        t_coord                x;
        t_coord                y;
        int                    want;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_coord                i_x_coord;
    t_coord                i_y_coord;
    logic                  o_done;
    t_count                o_iteration_count;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [DATA_WIDTH-1:0] pwdata;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    t_cfg     cfg_mirror;
    pending_t pending_counts[$];
    dir_row_t dir_rows[$];
    int       error_count;
    int       mismatch_count;
    int       points_sent;

    escape_time_fractal_iterator uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_x_coord         (i_x_coord),
        .i_y_coord         (i_y_coord),
        .o_done            (o_done),
        .o_iteration_count (o_iteration_count),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Give up if the run hangs.
    initial begin
        #40_000_000;
        $display("tb_escape_time_fractal_iterator: done, errors");
        $finish;
    end

    function automatic longint clamp_coord(longint v);
        if (v > COORD_HI) return COORD_HI;
        if (v < COORD_LO) return COORD_LO;
        return v;
    endfunction

    // Iterate z = z*z + c under the mirrored configuration and return the step count.
    function automatic t_count escape_count(t_coord x, t_coord y);
        longint      zr, zi, cr, ci, sq_re, sq_im;
        u64_t        thr, mag;
        int unsigned steps;
        steps = 0;
        if (cfg_mirror.mode == MODE_JULIA) begin
            zr  = x;
            zi  = y;
            cr  = cfg_mirror.julia_c_real;
            ci  = cfg_mirror.julia_c_imag;
            thr = u64_t'(cfg_mirror.julia_escape_limit) << FRAC_BITS;
        end else begin
            zr  = 0;
            zi  = 0;
            cr  = x;
            ci  = y;
            thr = u64_t'(cfg_mirror.mandel_escape_limit) << FRAC_BITS;
        end
        forever begin
            sq_re = zr * zr;
            sq_im = zi * zi;
            mag   = u64_t'(sq_re) + u64_t'(sq_im);
            if (steps >= cfg_mirror.max_iterations || !(mag < thr)) break;
            // Both products are floored to Q8.24, then the sums saturate.
            cr    = cr;
            sq_re = ((sq_re - sq_im) >>> FRAC_BITS) + cr;
            sq_im = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
            zr    = clamp_coord(sq_re);
            zi    = clamp_coord(sq_im);
            steps++;
        end
        return t_count'(steps);
    endfunction

    task automatic note_error(string what, t_count want, t_coord x, t_coord y);
        error_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
            $display("%0t: %s: point (%h, %h) expected count %0d, got %0d",
                     $realtime, what, x, y, want, o_iteration_count);
        end
    endtask

    // Check every count beat against the oldest point still due.
    always @(posedge i_clk) begin : count_check
        pending_t due;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_counts.size() == 0) begin
                note_error("count with no point pending", '0, '0, '0);
            end else begin
                due = pending_counts.pop_front();
                if (o_iteration_count !== due.count) begin
                    note_error("count mismatch", due.count, due.x, due.y);
                end
            end
        end
    end

    // Register write over the config port; the mirror follows at the write beat.
    task automatic reg_write(logic [IDX_WIDTH-1:0] idx, logic [DATA_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:       cfg_mirror.mode                = value[0];
            REG_MAX_ITER:   cfg_mirror.max_iterations      = value[COUNT_WIDTH-1:0];
            REG_JULIA_C_RE: cfg_mirror.julia_c_real        = value;
            REG_JULIA_C_IM: cfg_mirror.julia_c_imag        = value;
            REG_MANDEL_LIM: cfg_mirror.mandel_escape_limit = value[LIMIT_WIDTH-1:0];
            REG_JULIA_LIM:  cfg_mirror.julia_escape_limit  = value[LIMIT_WIDTH-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Present one point until its start beat; the sender idles at random per cycle, except after the first 1140 points.
    task automatic send_point(t_coord x, t_coord y, t_count want);
        int idle_pct;
        pending_t due;
        if (points_sent < 570)
            idle_pct = 19;
        else if (points_sent < 1140)
            idle_pct = 81;
        else
            idle_pct = 0;
        i_x_coord <= x;
        i_y_coord <= y;
        forever begin
            start <= ($urandom_range(0, 99) >= idle_pct);
            @(posedge i_clk);
            if (start === 1'b1 && busy === 1'b0) break;
        end
        due.count = want;
        due.x     = x;
        due.y     = y;
        pending_counts.push_back(due);
        points_sent++;
    endtask

    // Stop sending and wait for every pending count; leftovers are failures.
    task automatic drain_counts();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_counts.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_counts.size() != 0) begin
            error_count += pending_counts.size();
            $display("%0t: %0d points never produced a count",
                     $realtime, pending_counts.size());
            pending_counts.delete();
        end
        repeat (2) @(posedge i_clk);
    endtask

    // Random point: mostly inside the interesting window, sometimes anywhere.
    task automatic random_point(output t_coord x, output t_coord y);
        if ($urandom_range(0, 99) < 15) begin
            x = $urandom;
            y = $urandom;
        end else if (cfg_mirror.mode == MODE_JULIA) begin
            x = int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
            y = int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
        end else begin
            x = int'($urandom_range(0, 3 * ONE)) - (9 * ONE) / 4;
            y = int'($urandom_range(0, 3 * ONE)) - (3 * ONE) / 2;
        end
    endtask

    // Load a full configuration, then send random points under it.
    task automatic run_phase(logic [DATA_WIDTH-1:0] mode, logic [DATA_WIDTH-1:0] max_iter,
                             logic [DATA_WIDTH-1:0] c_re, logic [DATA_WIDTH-1:0] c_im,
                             logic [DATA_WIDTH-1:0] mandel_lim,
                             logic [DATA_WIDTH-1:0] julia_lim, int points);
        t_coord x, y;
        drain_counts();
        reg_write(REG_MODE, mode);
        reg_write(REG_MAX_ITER, max_iter);
        reg_write(REG_JULIA_C_RE, c_re);
        reg_write(REG_JULIA_C_IM, c_im);
        reg_write(REG_MANDEL_LIM, mandel_lim);
        reg_write(REG_JULIA_LIM, julia_lim);
        repeat (points) begin
            random_point(x, y);
            send_point(x, y, escape_count(x, y));
        end
    endtask

    task automatic add_write(logic [IDX_WIDTH-1:0] idx, logic [DATA_WIDTH-1:0] value);
        dir_row_t row;
        row          = '{default: '0};
        row.is_write = 1'b1;
        row.idx      = idx;
        row.value    = value;
        dir_rows.push_back(row);
    endtask

    task automatic add_point(t_coord x, t_coord y, int want);
        dir_row_t row;
        row      = '{default: '0};
        row.x    = x;
        row.y    = y;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    // Stimulus and final verdict.
    initial begin
        error_count    = 0;
        mismatch_count = 0;
        points_sent    = 0;
        cfg_mirror.mode                = MODE_MANDEL;
        cfg_mirror.max_iterations      = RST_MAX_ITER;
        cfg_mirror.julia_c_real        = RST_C_RE;
        cfg_mirror.julia_c_imag        = RST_C_IM;
        cfg_mirror.mandel_escape_limit = RST_MANDEL_LIM;
        cfg_mirror.julia_escape_limit  = RST_JULIA_LIM;
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_x_coord <= '0;
        i_y_coord <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;

        // Reset defaults: the origin and -1 never escape, far points escape after one step.
        add_point(0, 0, 100);
        add_point(-ONE, 0, 100);
        add_point(COORD_TOP, COORD_TOP, 1);
        add_point(COORD_BOT, COORD_BOT, 1);
        add_point(COORD_BOT, COORD_TOP, 1);
        add_point(32'h5555_5555, 32'hAAAA_AAAA, 1);
        add_point(32'hAAAA_AAAA, 32'h5555_5555, 1);
        add_point(ONE / 4, 0, NO_WANT);
        add_point(-12582912, 1677722, NO_WANT);
        add_point(0, ONE, NO_WANT);
        // A zero iteration limit gives a zero count.
        add_write(REG_MAX_ITER, 0);
        add_point(ONE / 4, ONE / 4, 0);
        // A zero threshold stops before the first step, even at the top limit.
        add_write(REG_MAX_ITER, 1023);
        add_write(REG_MANDEL_LIM, 0);
        add_point(0, 0, 0);
        add_write(REG_MANDEL_LIM, LIMIT_TOP);
        add_write(REG_MAX_ITER, 20);
        add_point(-2 * ONE, 0, NO_WANT);
        // Julia with extreme constants drives z into saturation.
        add_write(REG_MODE, MODE_JULIA);
        add_write(REG_JULIA_C_RE, COORD_TOP);
        add_write(REG_JULIA_C_IM, COORD_TOP);
        add_write(REG_JULIA_LIM, LIMIT_TOP);
        add_point(10 * ONE, 0, NO_WANT);
        add_point(8 * ONE, 8 * ONE, NO_WANT);
        add_write(REG_JULIA_C_RE, COORD_BOT);
        add_write(REG_JULIA_C_IM, COORD_BOT);
        add_point(0, 10 * ONE, NO_WANT);
        add_point(-8 * ONE, 8 * ONE, NO_WANT);
        add_write(REG_JULIA_LIM, 0);
        add_point(0, 0, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table.
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_write) begin
                drain_counts();
                reg_write(dir_rows[i].idx, dir_rows[i].value);
            end else if (dir_rows[i].want == NO_WANT) begin
                send_point(dir_rows[i].x, dir_rows[i].y,
                           escape_count(dir_rows[i].x, dir_rows[i].y));
            end else begin
                send_point(dir_rows[i].x, dir_rows[i].y, t_count'(dir_rows[i].want));
            end
        end

        // Fixed configurations: defaults, other constants, top limit, tiny limits.
        run_phase(MODE_MANDEL, RST_MAX_ITER, RST_C_RE, RST_C_IM,
                  RST_MANDEL_LIM, RST_JULIA_LIM, 600);
        run_phase(MODE_JULIA, RST_MAX_ITER, RST_C_RE, RST_C_IM,
                  RST_MANDEL_LIM, RST_JULIA_LIM, 500);
        run_phase(MODE_JULIA, 255, -13421773, 2617245, RST_MANDEL_LIM, 4 * ONE, 200);
        run_phase(MODE_MANDEL, 1023, RST_C_RE, RST_C_IM, 4 * ONE, RST_JULIA_LIM, 25);
        run_phase(MODE_JULIA, 1023, -6710886, 10066330, RST_MANDEL_LIM, 4 * ONE, 25);
        run_phase(MODE_MANDEL, 1, COORD_TOP, COORD_BOT, LIMIT_TOP, LIMIT_TOP, 40);
        run_phase(MODE_JULIA, 0, COORD_BOT, COORD_TOP, 0, 0, 40);
        run_phase(MODE_MANDEL, 40, COORD_BOT, COORD_BOT, LIMIT_TOP, 0, 60);

        // Random configurations; unused upper bits of the mode, limit and threshold registers are set at random.
        repeat (4) begin
            run_phase($urandom,
                      ($urandom & 32'hFFFF_FC00) | $urandom_range(1, 64),
                      ($urandom_range(0, 1) != 0) ?
                          32'(int'($urandom_range(0, 3 * ONE)) - (3 * ONE) / 2) : $urandom,
                      ($urandom_range(0, 1) != 0) ?
                          32'(int'($urandom_range(0, 3 * ONE)) - (3 * ONE) / 2) : $urandom,
                      ($urandom & 32'h8000_0000) | $urandom_range(ONE, 16 * ONE),
                      ($urandom & 32'h8000_0000) | $urandom_range(ONE, 16 * ONE),
                      50);
        end

        drain_counts();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_escape_time_fractal_iterator: done, clean");
        end else begin
            $display("tb_escape_time_fractal_iterator: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/etf_pkg.sv
hw/rtl/etf_regs.sv
hw/rtl/etf_sq_unit.sv
hw/rtl/escape_time_fractal_iterator.sv
hw/rtl/etf_checker.sv
bench/tb_escape_time_fractal_iterator.sv
